### design/priority_ready_queue_unit_defines.svh
// Assertion helpers for the ready queue.
`ifndef PRIORITY_READY_QUEUE_UNIT_DEFINES_SVH
`define PRIORITY_READY_QUEUE_UNIT_DEFINES_SVH

// Checked outside reset.
`define PRQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PRQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/prq_pkg.sv
`default_nettype none
package prq_pkg;
    localparam int CAPACITY  = 16;
    localparam int PRI_W     = 8;
    localparam int ARR_W     = 32;
    localparam int ID_W      = 16;
    localparam int STORED_W  = 5;
    localparam int ENTRY_W   = PRI_W + ARR_W + ID_W;
    localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Field order gives the ranking: a plain unsigned compare of two entries
    // is the priority / arrival / id tie-break.
    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [ARR_W-1:0] arr;
        logic [ID_W-1:0]  id;
    } t_entry;

    typedef struct packed {
        logic                accepted;
        logic                out_valid;
        logic [ID_W-1:0]     out_id;
        logic [PRI_W-1:0]    out_priority;
        logic [ARR_W-1:0]    out_arrival_time;
        logic                now_empty;
        logic [STORED_W-1:0] stored_count;
    } t_result;

    // Ring position of a logical slot counted from the head.
    function automatic logic [AW-1:0] prq_phys(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(CAPACITY)) begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction
endpackage
`default_nettype wire

### design/prq_if.sv
`default_nettype none
interface prq_in_if;
    import prq_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PRI_W-1:0] entry_priority;
    logic [ARR_W-1:0] entry_arrival_time;
    logic [ID_W-1:0]  entry_id;

    modport source (output valid, mode, entry_priority, entry_arrival_time, entry_id,
                    input ready);
    modport sink   (input valid, mode, entry_priority, entry_arrival_time, entry_id,
                    output ready);
endinterface

interface prq_out_if;
    import prq_pkg::*;
    logic                valid;
    logic                ready;
    logic                accepted;
    logic                out_valid;
    logic [ID_W-1:0]     out_id;
    logic [PRI_W-1:0]    out_priority;
    logic [ARR_W-1:0]    out_arrival_time;
    logic                now_empty;
    logic [STORED_W-1:0] stored_count;

    modport source (output valid, accepted, out_valid, out_id, out_priority,
                    out_arrival_time, now_empty, stored_count, input ready);
    modport sink   (input valid, accepted, out_valid, out_id, out_priority,
                    out_arrival_time, now_empty, stored_count, output ready);
endinterface
`default_nettype wire

### design/prq_ram.sv
`default_nettype none
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

### design/priority_ready_queue_unit.sv
// Sorted ready queue of up to 16 task entries in a ring buffer held in one
// single-port-write, registered-read RAM. Each transaction enqueues or dequeues
// and returns exactly one result. The result register is loaded as the block
// returns to S_IDLE, where the next transaction can be accepted. A dequeue
// goes through head read, head advance (S_DEQ) and hand-off (S_FIN). An enqueue
// into a queue holding n > 0 entries walks back from the tail, one RAM read and
// one shifted write per cycle, until the entry finds its insert position or
// reaches the head (S_PLACE). An enqueue into an empty queue, a full-queue
// enqueue and an empty-queue dequeue go straight to S_FIN. A result not yet
// taken at the output holds the next one in S_FIN.
// A new transaction is taken while an earlier result is still waiting on the
// output; the block works on one transaction at a time.
`default_nettype none
`include "priority_ready_queue_unit_defines.svh"
module priority_ready_queue_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prq_in_if.sink    i_in,
    prq_out_if.source o_out
);
    import prq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_DEQ   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_k, n_k;
    t_entry           r_new, n_new;
    t_result          r_res, n_res;
    t_result          r_out, n_out;
    logic             r_out_vld, n_out_vld;

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    t_entry           wr_data, rd_data;
    t_entry           in_entry;
    logic             in_fire;

    prq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_entry   = '{pri: i_in.entry_priority, arr: i_in.entry_arrival_time,
                          id: i_in.entry_id};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_k       = r_k;
        n_new     = r_new;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        wr_en     = 1'b0;
        wr_addr   = r_head;
        wr_data   = r_new;
        rd_en     = 1'b0;
        rd_addr   = r_head;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_new              = in_entry;
                    n_res              = '0;
                    n_res.stored_count = STORED_W'(r_count);
                    n_res.now_empty    = (r_count == '0);
                    if (i_in.mode == MODE_DEQ) begin
                        if (r_count == '0) begin
                            n_state = S_FIN;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_state = S_DEQ;
                        end
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_state = S_FIN;
                    end else if (r_count == '0) begin
                        wr_en              = 1'b1;
                        wr_addr            = r_head;
                        wr_data            = in_entry;
                        n_count            = CNT_W'(1);
                        n_res.accepted     = 1'b1;
                        n_res.now_empty    = 1'b0;
                        n_res.stored_count = STORED_W'(1);
                        n_state            = S_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = prq_phys(r_head, AW'(r_count - 1'b1));
                        n_k     = AW'(r_count - 1'b1);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                wr_en   = 1'b1;
                wr_addr = prq_phys(r_head, r_k + AW'(1));
                if (r_new < rd_data) begin
                    wr_data = rd_data;
                    if (r_k == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = prq_phys(r_head, r_k - AW'(1));
                        n_k     = r_k - AW'(1);
                    end
                end else begin
                    wr_data            = r_new;
                    n_count            = r_count + 1'b1;
                    n_res.accepted     = 1'b1;
                    n_res.now_empty    = 1'b0;
                    n_res.stored_count = STORED_W'(r_count + 1'b1);
                    n_state            = S_FIN;
                end
            end
            S_PLACE: begin
                wr_en              = 1'b1;
                wr_addr            = r_head;
                wr_data            = r_new;
                n_count            = r_count + 1'b1;
                n_res.accepted     = 1'b1;
                n_res.now_empty    = 1'b0;
                n_res.stored_count = STORED_W'(r_count + 1'b1);
                n_state            = S_FIN;
            end
            S_DEQ: begin
                n_res.out_valid        = 1'b1;
                n_res.out_id           = rd_data.id;
                n_res.out_priority     = rd_data.pri;
                n_res.out_arrival_time = rd_data.arr;
                n_res.now_empty        = (r_count == CNT_W'(1));
                n_res.stored_count     = STORED_W'(r_count - 1'b1);
                n_head                 = prq_phys(r_head, AW'(1));
                n_count                = r_count - 1'b1;
                n_state                = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_k       <= n_k;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.accepted         = r_out.accepted;
    assign o_out.out_valid        = r_out.out_valid;
    assign o_out.out_id           = r_out.out_id;
    assign o_out.out_priority     = r_out.out_priority;
    assign o_out.out_arrival_time = r_out.out_arrival_time;
    assign o_out.now_empty        = r_out.now_empty;
    assign o_out.stored_count     = r_out.stored_count;

    `PRQ_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "fill count above capacity")
    `PRQ_ASSERT(a_no_rw_clash, (wr_en && rd_en) |-> (wr_addr != rd_addr),
        "shift write hits the slot being read")
    `PRQ_ASSERT(a_result_kind, o_out.valid |-> !(o_out.accepted && o_out.out_valid),
        "result flags both enqueue and dequeue")
    `PRQ_ASSERT(a_empty_flag,
        o_out.valid |-> (o_out.now_empty == (o_out.stored_count == '0)),
        "empty flag disagrees with count")
    `PRQ_ASSERT(a_count_step,
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
                  || r_count == $past(r_count) - 1'b1),
        "fill count moved by more than one")
endmodule
`default_nettype wire
